// ===== design/sensor_fault_debounce_hold_defines.svh =====
// Assertion macros shared by the sensor fault debounce design.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SENSOR_FAULT_DEBOUNCE_HOLD_DEFINES_SVH
`define SENSOR_FAULT_DEBOUNCE_HOLD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SFDH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfdh assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SFDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfdh assertion failed");

`endif

// ===== design/sfdh_pkg.sv =====
// Package for the sensor fault debounce and hold block: constants,
// register indexes and the control structs between its modules. No dependencies.
package sfdh_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int TEMP_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]        ERR_NONE        = 8'h00;
  localparam logic [7:0]        NO_STATUS_CODE  = 8'h08;
  localparam logic [7:0]        COUNT_MAX       = 8'hFF;
  localparam logic [7:0]        THRESHOLD_RESET = 8'd6;
  // 25.0 degC in 1/16 degC
  localparam logic signed [15:0] FALLBACK_RESET = 16'sd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAULT_THRESHOLD = 1'b0,
    REG_FALLBACK_TEMP   = 1'b1
  } cfg_reg_e;

  // Control part of one reading
  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] device_status;
    logic       sample_invalid;
  } sfdh_req_t;

  // Status part of one result
  typedef struct packed {
    logic [7:0] error_code;
    logic       persistent_fault;
    logic       all_healthy;
  } sfdh_res_t;

endpackage

// ===== design/sfdh_if.sv =====
// Valid/ready channel interfaces for readings and results.
// Depends on nothing; the width parameter matches the top level's TEMP_BITS.
interface sfdh_in_if #(
  parameter int TEMP_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  channel;
  logic signed [TEMP_BITS-1:0] temperature_in;
  logic [7:0]                  device_status;
  logic                        sample_invalid;

  modport source (output valid, channel, temperature_in, device_status, sample_invalid,
                  input ready);
  modport sink   (input valid, channel, temperature_in, device_status, sample_invalid,
                  output ready);
endinterface

interface sfdh_out_if #(
  parameter int TEMP_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [TEMP_BITS-1:0] temperature_out;
  logic [7:0]                  error_code;
  logic                        persistent_fault;
  logic                        all_healthy;

  modport source (output valid, temperature_out, error_code, persistent_fault, all_healthy,
                  input ready);
  modport sink   (input valid, temperature_out, error_code, persistent_fault, all_healthy,
                  output ready);
endinterface

// ===== design/sfdh_chan_regs.sv =====
// Per-channel state (held temperature, bad count, fault mask) and the
// read-modify-write that evaluates one reading. Uses sfdh_pkg.
module sfdh_chan_regs import sfdh_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TEMP_BITS = TEMP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  fault_threshold_i,
  input  logic signed [TEMP_BITS-1:0] fallback_temp_i,
  input  logic                        commit_i,
  input  sfdh_req_t                   req_i,
  input  logic signed [TEMP_BITS-1:0] temp_i,
  output logic signed [TEMP_BITS-1:0] temp_o,
  output sfdh_res_t                   res_o
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [TEMP_BITS-1:0] held_temp_q [CHANNELS];
  logic [CHANNELS-1:0]         has_valid_q;
  logic [7:0]                  bad_count_q [CHANNELS];
  logic [CHANNELS-1:0]         fault_mask_q, fault_mask_d;

  logic                in_range;
  logic [CH_IDX_W-1:0] idx;
  logic                good;
  logic [7:0]          count_inc;
  logic                set_fault;

  // Decode the reading
  assign in_range = (32'(req_i.channel) < CHANNELS);
  assign idx      = CH_IDX_W'(req_i.channel);
  assign good     = !req_i.sample_invalid && (req_i.device_status == ERR_NONE);

  // Saturating count and threshold compare
  assign count_inc = (bad_count_q[idx] == COUNT_MAX) ? COUNT_MAX : bad_count_q[idx] + 8'd1;
  assign set_fault = (count_inc >= fault_threshold_i);

  // Updated fault mask
  always_comb begin
    fault_mask_d = fault_mask_q;
    if (in_range) begin
      if (good) begin
        fault_mask_d[idx] = 1'b0;
      end else if (set_fault) begin
        fault_mask_d[idx] = 1'b1;
      end
    end
  end

  // Result of this reading
  always_comb begin
    if (!in_range) begin
      temp_o               = fallback_temp_i;
      res_o.error_code     = NO_STATUS_CODE;
      res_o.persistent_fault = 1'b0;
    end else if (good) begin
      temp_o               = temp_i;
      res_o.error_code     = ERR_NONE;
      res_o.persistent_fault = 1'b0;
    end else begin
      temp_o               = has_valid_q[idx] ? held_temp_q[idx] : fallback_temp_i;
      res_o.error_code     = (req_i.device_status != ERR_NONE) ? req_i.device_status
                                                               : NO_STATUS_CODE;
      res_o.persistent_fault = fault_mask_d[idx];
    end
    res_o.all_healthy = (fault_mask_d == '0);
  end

  // Control state: counts, valid flags, fault mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_valid_q  <= '0;
      fault_mask_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        bad_count_q[i] <= '0;
      end
    end else if (commit_i && in_range) begin
      fault_mask_q <= fault_mask_d;
      if (good) begin
        has_valid_q[idx] <= 1'b1;
        bad_count_q[idx] <= '0;
      end else begin
        bad_count_q[idx] <= count_inc;
      end
    end
  end

  // Held temperatures; read only once the valid flag is set
  always_ff @(posedge clk_i) begin
    if (commit_i && in_range && good) begin
      held_temp_q[idx] <= temp_i;
    end
  end

endmodule

// ===== design/sensor_fault_debounce_hold.sv =====
// Sensor fault debounce and hold: takes one reading per transaction, one
// transaction per clock cycle while the output is not stalled, and returns
// one result per reading from the output register. The reading lands in
// an input register; the per-channel state is then read, updated and written
// back while the result is loaded into the output register, so consecutive
// readings of the same channel see each other's effects with no bubbles. A
// stalled output holds its result while one more reading waits in the input
// register. Registers: index 0 fault threshold, index 1 fallback temperature
// (returned by channels with no good reading yet, effective at once).
`include "sensor_fault_debounce_hold_defines.svh"

module sensor_fault_debounce_hold import sfdh_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TEMP_BITS = TEMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfdh_in_if.sink               sample_i,
  sfdh_out_if.source            result_o
);

  logic [7:0]         fault_threshold_q;
  logic signed [15:0] fallback_temp_q;

  logic                        s1_valid_q;
  sfdh_req_t                   s1_req_q;
  logic signed [TEMP_BITS-1:0] s1_temp_q;

  logic                        out_valid_q;
  logic signed [TEMP_BITS-1:0] out_temp_q;
  sfdh_res_t                   out_res_q;

  logic                        advance;
  logic                        accept;
  logic signed [TEMP_BITS-1:0] res_temp;
  sfdh_res_t                   res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_threshold_q <= THRESHOLD_RESET;
      fallback_temp_q   <= FALLBACK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FAULT_THRESHOLD: fault_threshold_q <= cfg_data_i[7:0];
        REG_FALLBACK_TEMP:   fallback_temp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on when the output register is free
  assign advance        = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || advance;
  assign accept         = sample_i.valid && sample_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q.channel        <= sample_i.channel;
      s1_req_q.device_status  <= sample_i.device_status;
      s1_req_q.sample_invalid <= sample_i.sample_invalid;
      s1_temp_q               <= sample_i.temperature_in;
    end
  end

  // Channel state and evaluation
  sfdh_chan_regs #(
    .CHANNELS  (CHANNELS),
    .TEMP_BITS (TEMP_BITS)
  ) u_chan_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fault_threshold_i (fault_threshold_q),
    .fallback_temp_i   (TEMP_BITS'(fallback_temp_q)),
    .commit_i          (advance),
    .req_i             (s1_req_q),
    .temp_i            (s1_temp_q),
    .temp_o            (res_temp),
    .res_o             (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_temp_q <= res_temp;
      out_res_q  <= res;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.temperature_out  = out_temp_q;
  assign result_o.error_code       = out_res_q.error_code;
  assign result_o.persistent_fault = out_res_q.persistent_fault;
  assign result_o.all_healthy      = out_res_q.all_healthy;

  // Checks
  `SFDH_ASSERT_NOW(a_good_no_fault, clk_i, rst_ni, result_o.valid && (result_o.error_code == ERR_NONE), !result_o.persistent_fault)
  `SFDH_ASSERT_NOW(a_fault_not_healthy, clk_i, rst_ni, result_o.valid && result_o.persistent_fault, !result_o.all_healthy)
  `SFDH_ASSERT_NOW(a_full_blocks_input, clk_i, rst_ni, s1_valid_q && out_valid_q && !result_o.ready, !sample_i.ready)
  `SFDH_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, result_o.valid)

endmodule
